// ===== src/crcfr_pkg.sv =====
package crcfr_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int WPOS_W       = $clog2(BUFFER_DEPTH + 1);
	localparam int MAX_READ     = 64;
	localparam int READ_CAP     = (BUFFER_DEPTH < MAX_READ) ? BUFFER_DEPTH : MAX_READ;
	localparam int CNT_W        = $clog2(READ_CAP);
	localparam int MAX_LEN      = BUFFER_DEPTH - 5;
	localparam int HDR_BYTES    = 3;
	localparam int QDEPTH       = 4;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam logic [7:0]  START_RESET   = 8'd2;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_START   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_ACCEPT    = 3'd1,
		EV_CRC_BAD   = 3'd2,
		EV_LEN_ABORT = 3'd3,
		EV_TIMEOUT   = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_CMD    = 3'd1,
		PH_LEN    = 3'd2,
		PH_DATA   = 3'd3,
		PH_CRC_LO = 3'd4,
		PH_CRC_HI = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
		logic       line_error;
		logic [6:0] read_count;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       last;
		logic       rx_busy;
		logic       pkt_waiting;
		logic [6:0] packet_length;
		logic [2:0] frame_event;
	} out_t;

	typedef struct packed {
		logic       is_read;
		logic [6:0] count;
		logic       busy;
		logic       ready;
		logic [6:0] len;
		logic [2:0] frame_event;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crc_framed_packet_receiver_core.sv =====
// Path: an accepted request passes the command queue, valid_s1/meta_s1 and the output stage.
// Throughput: one byte or tick request per cycle while the queue has room and no readout is
// pending; the command queue between parser and result unit is four deep. A read request streams
// one stored byte per cycle while the output stage has room, and holds further requests until
// its last byte address has gone to the frame store read port.
// Reset: arst_n clears parser, flags, counters, queues; registers return to start 2, timeout 100.
module crc_framed_packet_receiver_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  crcfr_pkg::in_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output crcfr_pkg::out_t                  rsp
);
	import crcfr_pkg::*;

	// front to queue
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	// queue to back
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;
	// back to front: a readout has issued its final read
	logic read_done;
	// frame store write port, driven by the parser
	wr_t  wr;

	// Parser: takes each request, advances the frame state, updates the CRC,
	// writes frame bytes and posts one command describing the results.
	crcfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full),
		.read_done (read_done),
		.wr        (wr)
	);

	// Short command queue: decouples the parser from a stalled result side.
	crcfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.valid  (q_valid),
		.dout   (q_cmd),
		.pop    (q_pop)
	);

	// Result unit: owns the frame store, expands a read command into byte
	// results, and buffers results in a two-entry output stage so that a
	// stalled consumer never loses an in-flight read.
	crcfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.read_done (read_done),
		.wr        (wr),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// After a read request, hold the request side until the readout has issued its final read.
	a_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.opcode == OP_READ) |=> !req_ready)
		else $error("request taken while a readout was pending");

	// Byte results never carry an event or a ready packet.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind |-> (rsp.frame_event == EV_NONE) && !rsp.pkt_waiting)
		else $error("packet byte result carries status");

	// A status result is always the only, hence last, result of its request.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.kind |-> rsp.last)
		else $error("status result without last");

	// A ready packet always has a nonzero stored length.
	a_ready_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.pkt_waiting |-> (rsp.packet_length != 7'd0))
		else $error("ready packet with zero length");

endmodule

// ===== src/crcfr_front.sv =====
module crcfr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [crcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crcfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  crcfr_pkg::in_t                     req,
	output logic                               cmd_push,
	output crcfr_pkg::cmd_t                    cmd,
	input  logic                               cmd_full,
	input  logic                               read_done,
	output crcfr_pkg::wr_t                     wr
);
	import crcfr_pkg::*;

	logic [7:0]        start_q;
	logic [15:0]       timeout_q;
	phase_t            phase_q, phase_d;
	logic [WPOS_W-1:0] wpos_q, wpos_d;
	logic [7:0]        decl_q, decl_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        crc_lo_q, crc_lo_d;
	logic              ready_q, ready_d;
	logic              busy_q, busy_d;
	logic [15:0]       idle_q, idle_d;
	logic              read_busy_q;
	logic              take;
	logic [WPOS_W-1:0] wpos_inc;
	logic [8:0]        data_end;
	logic [15:0]       idle_inc;
	logic [6:0]        cnt_cap;
	event_t            ev;

	// hold new requests while a readout is still draining the frame store
	assign req_ready = !cmd_full && !read_busy_q;
	assign take      = req_valid && req_ready;
	assign wpos_inc  = wpos_q + 1'b1;
	assign data_end  = 9'(HDR_BYTES) + {1'b0, decl_q};
	assign idle_inc  = (idle_q != IDLE_MAX) ? idle_q + 16'd1 : idle_q;
	assign cnt_cap   = (req.read_count > 7'(READ_CAP)) ? 7'(READ_CAP) : req.read_count;

	always_comb begin
		phase_d  = phase_q;
		wpos_d   = wpos_q;
		decl_d   = decl_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		ready_d  = ready_q;
		busy_d   = busy_q;
		idle_d   = idle_q;
		ev       = EV_NONE;
		wr.en    = 1'b0;
		wr.addr  = ADDR_W'(wpos_q);
		wr.data  = req.rx_byte;
		if (take) begin
			case (req.opcode)
				OP_BYTE: begin
					if (!ready_q && !req.line_error) begin
						idle_d = '0;
						if (phase_q inside {PH_CMD, PH_LEN, PH_DATA, PH_CRC_LO, PH_CRC_HI}) begin
							wr.en  = (wpos_q < WPOS_W'(BUFFER_DEPTH));
							wpos_d = wpos_inc;
						end
						case (phase_q)
							PH_CMD: begin
								crc_d   = crc_update(crc_q, req.rx_byte);
								phase_d = PH_LEN;
							end
							PH_LEN: begin
								crc_d  = crc_update(crc_q, req.rx_byte);
								decl_d = req.rx_byte;
								if (req.rx_byte > 8'(MAX_LEN)) begin
									phase_d = PH_WAIT;
									busy_d  = 1'b0;
									ev      = EV_LEN_ABORT;
								end else if (req.rx_byte == 8'd0) begin
									phase_d = PH_CRC_LO;
								end else begin
									phase_d = PH_DATA;
								end
							end
							PH_DATA: begin
								crc_d = crc_update(crc_q, req.rx_byte);
								if (9'(wpos_inc) >= data_end) begin
									phase_d = PH_CRC_LO;
								end
							end
							PH_CRC_LO: begin
								crc_lo_d = req.rx_byte;
								phase_d  = PH_CRC_HI;
							end
							PH_CRC_HI: begin
								if (crc_q == {req.rx_byte, crc_lo_q}) begin
									ready_d = 1'b1;
									ev      = EV_ACCEPT;
								end else begin
									ev = EV_CRC_BAD;
								end
								busy_d  = 1'b0;
								phase_d = PH_WAIT;
							end
							default: begin
								phase_d = PH_WAIT;
								if (req.rx_byte == start_q) begin
									busy_d  = 1'b1;
									wr.en   = 1'b1;
									wr.addr = '0;
									wpos_d  = WPOS_W'(1);
									crc_d   = crc_update(CRC_INIT, req.rx_byte);
									phase_d = PH_CMD;
								end
							end
						endcase
					end
				end
				OP_TICK: begin
					idle_d = idle_inc;
					if (phase_q != PH_WAIT && idle_inc > timeout_q) begin
						phase_d = PH_WAIT;
						busy_d  = 1'b0;
						ev      = EV_TIMEOUT;
					end
				end
				OP_READ: begin
					ready_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign cmd_push        = take;
	assign cmd.is_read     = (req.opcode == OP_READ);
	assign cmd.count       = cnt_cap;
	assign cmd.busy        = busy_d;
	assign cmd.ready       = ready_d;
	assign cmd.len         = ready_d ? 7'(wpos_d) : 7'd0;
	assign cmd.frame_event = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_RESET;
			timeout_q   <= TIMEOUT_RESET;
			phase_q     <= PH_WAIT;
			wpos_q      <= '0;
			decl_q      <= '0;
			crc_q       <= CRC_INIT;
			crc_lo_q    <= '0;
			ready_q     <= 1'b0;
			busy_q      <= 1'b0;
			idle_q      <= '0;
			read_busy_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_START:   start_q   <= cfg_data[7:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			phase_q  <= phase_d;
			wpos_q   <= wpos_d;
			decl_q   <= decl_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			ready_q  <= ready_d;
			busy_q   <= busy_d;
			idle_q   <= idle_d;
			if (take && req.opcode == OP_READ) begin
				read_busy_q <= 1'b1;
			end else if (read_done) begin
				read_busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/crcfr_queue.sv =====
module crcfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  crcfr_pkg::cmd_t din,
	output logic            full,
	output logic            valid,
	output crcfr_pkg::cmd_t dout,
	input  logic            pop
);
	import crcfr_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	cmd_t              q_q [QDEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_QW'(QDEPTH));
	assign valid   = (count_q != '0);
	assign dout    = q_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CNT_QW'(do_push) - CNT_QW'(do_pop);
		end
	end

endmodule

// ===== src/crcfr_back.sv =====
module crcfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  crcfr_pkg::cmd_t cmd,
	output logic            cmd_pop,
	output logic            read_done,
	input  crcfr_pkg::wr_t  wr,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output crcfr_pkg::out_t rsp
);
	import crcfr_pkg::*;

	logic [7:0]       mem_q [BUFFER_DEPTH];
	logic [7:0]       rdata_s1;
	logic             valid_s1;
	out_t             meta_s1;
	logic [CNT_W-1:0] k_q;
	out_t             ent_q [2];
	logic             wsel_q, rsel_q;
	logic [1:0]       ocnt_q;
	logic [2:0]       occ;
	logic             pop, issue, single, is_last, issue_rd;
	out_t             landed;

	assign pop     = rsp_valid && rsp_ready;
	assign occ     = {1'b0, ocnt_q} + {2'b00, valid_s1} - {2'b00, pop};
	assign issue   = cmd_valid && (occ <= 3'd1);
	assign single  = !cmd.is_read || (cmd.count == 7'd0);
	assign is_last = single || (7'({1'b0, k_q} + 1'b1) == cmd.count);
	assign issue_rd = issue && !single;

	assign cmd_pop   = issue && is_last;
	assign read_done = cmd_pop && cmd.is_read;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (issue_rd) begin
			rdata_s1 <= mem_q[ADDR_W'(k_q)];
		end
		if (issue) begin
			meta_s1.kind          <= !single;
			meta_s1.data_byte     <= 8'd0;
			meta_s1.last          <= is_last;
			meta_s1.rx_busy       <= cmd.busy;
			meta_s1.pkt_waiting   <= cmd.ready;
			meta_s1.packet_length <= cmd.len;
			meta_s1.frame_event   <= single ? cmd.frame_event : EV_NONE;
		end
	end

	always_comb begin
		landed = meta_s1;
		if (meta_s1.kind) begin
			landed.data_byte = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ent_q[wsel_q] <= landed;
		end
	end

	assign rsp_valid = (ocnt_q != 2'd0);
	assign rsp       = ent_q[rsel_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_q      <= '0;
			wsel_q   <= 1'b0;
			rsel_q   <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			valid_s1 <= issue;
			if (issue_rd) begin
				k_q <= is_last ? '0 : k_q + 1'b1;
			end
			if (valid_s1) begin
				wsel_q <= !wsel_q;
			end
			if (pop) begin
				rsel_q <= !rsel_q;
			end
			ocnt_q <= ocnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

endmodule

// ===== verif/crc_framed_packet_receiver_core_tb.sv =====
module crc_framed_packet_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crcfr_pkg::*;

	// Cycles without any request or result moving before the run is declared hung.
	localparam int STALL_LIMIT = 3000;
	// Length of the one long hold-off on the result side.
	localparam int LONG_HOLD = 200;

	// Frame predictor plus the queue of results it has promised.
	class rx_frame_scoreboard;
		logic [7:0]  start_cfg;
		logic [15:0] timeout_cfg;
		phase_t      phase;
		int          wpos;
		logic [7:0]  decl_len;
		logic [7:0]  store [BUFFER_DEPTH];
		logic [15:0] crc;
		bit          pkt_ready;
		bit          busy;
		logic [15:0] idle;
		int          written_hw;
		out_t        expected_q [$];
		int          errors;

		function new();
			start_cfg = START_RESET;
			timeout_cfg = TIMEOUT_RESET;
			phase = PH_WAIT;
			wpos = 0;
			decl_len = 8'h00;
			foreach (store[i]) store[i] = 8'h00;
			crc = CRC_INIT;
			pkt_ready = 1'b0;
			busy = 1'b0;
			idle = 16'h0000;
			written_hw = 0;
			errors = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_START: start_cfg = val[7:0];
				REG_TIMEOUT: timeout_cfg = val[15:0];
				default: ;
			endcase
		endfunction

		static function logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = c;
			for (int i = 7; i >= 0; i--) begin
				fb = r[15] ^ b[i];
				r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
			return r;
		endfunction

		function void save_byte(logic [7:0] b);
			if (wpos < BUFFER_DEPTH)
				store[wpos] = b;
			wpos++;
			if (wpos > written_hw)
				written_hw = wpos;
		endfunction

		function event_t parse_byte(logic [7:0] b);
			event_t ev;
			ev = EV_NONE;
			case (phase)
				PH_CMD: begin
					save_byte(b);
					crc = crc16_next(crc, b);
					phase = PH_LEN;
				end
				PH_LEN: begin
					save_byte(b);
					crc = crc16_next(crc, b);
					decl_len = b;
					if (b > MAX_LEN) begin
						phase = PH_WAIT;
						busy = 1'b0;
						ev = EV_LEN_ABORT;
					end else if (b == 8'h00) begin
						phase = PH_CRC_LO;
					end else begin
						phase = PH_DATA;
					end
				end
				PH_DATA: begin
					save_byte(b);
					crc = crc16_next(crc, b);
					if (wpos >= HDR_BYTES + decl_len)
						phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					save_byte(b);
					phase = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					save_byte(b);
					if (crc == {b, store[wpos-2]}) begin
						pkt_ready = 1'b1;
						ev = EV_ACCEPT;
					end else begin
						ev = EV_CRC_BAD;
					end
					busy = 1'b0;
					phase = PH_WAIT;
				end
				default: begin
					phase = PH_WAIT;
					if (b == start_cfg) begin
						busy = 1'b1;
						wpos = 0;
						save_byte(b);
						crc = crc16_next(CRC_INIT, b);
						phase = PH_CMD;
					end
				end
			endcase
			return ev;
		endfunction

		function out_t status_word(event_t ev);
			out_t o;
			o = '0;
			o.last = 1'b1;
			o.rx_busy = busy;
			o.pkt_waiting = pkt_ready;
			o.packet_length = pkt_ready ? 7'(wpos) : 7'd0;
			o.frame_event = ev;
			return o;
		endfunction

		function void note_request(in_t r);
			event_t ev;
			out_t   o;
			int     cnt;
			ev = EV_NONE;
			cnt = 0;
			case (opcode_t'(r.opcode))
				OP_BYTE: begin
					if (!pkt_ready && !r.line_error) begin
						idle = 16'h0000;
						ev = parse_byte(r.rx_byte);
					end
				end
				OP_TICK: begin
					if (idle != IDLE_MAX)
						idle++;
					if (phase != PH_WAIT && idle > timeout_cfg) begin
						phase = PH_WAIT;
						busy = 1'b0;
						ev = EV_TIMEOUT;
					end
				end
				OP_READ: begin
					pkt_ready = 1'b0;
					cnt = (r.read_count > READ_CAP) ? READ_CAP : r.read_count;
					for (int k = 0; k < cnt; k++) begin
						o = status_word(EV_NONE);
						o.kind = 1'b1;
						o.data_byte = store[k];
						o.last = (k == cnt - 1);
						expected_q.push_back(o);
					end
				end
				default: ;
			endcase
			if (cnt == 0)
				expected_q.push_back(status_word(ev));
		endfunction

		function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (exp_v !== got_v) begin
				$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: result %h arrived with nothing expected", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			cmp_field("kind", exp_r.kind, got.kind);
			cmp_field("data_byte", exp_r.data_byte, got.data_byte);
			cmp_field("last", exp_r.last, got.last);
			cmp_field("rx_busy", exp_r.rx_busy, got.rx_busy);
			cmp_field("pkt_waiting", exp_r.pkt_waiting, got.pkt_waiting);
			cmp_field("packet_length", exp_r.packet_length, got.packet_length);
			cmp_field("frame_event", exp_r.frame_event, got.frame_event);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	in_t                   req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	out_t                  rsp;

	rx_frame_scoreboard sb;
	bit idle_on = 1'b1;        // random gaps and stalls allowed
	int hold_off_cycles = 0;   // set once to ask the result side for a long hold-off
	int counted = 0;           // requests sent so far

	crc_framed_packet_receiver_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic in_t mk(opcode_t op, logic [7:0] b, logic le, logic [6:0] cnt);
		in_t r;
		r.opcode = op;
		r.rx_byte = b;
		r.line_error = le;
		r.read_count = cnt;
		return r;
	endfunction

	// Offer one request and hold it until accepted; the predictor sees it at the
	// accepting edge. Values read right after the edge are the ones the block saw.
	task automatic push_request(in_t item);
		counted++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(item);
	endtask

	task automatic send_tick();
		push_request(mk(OP_TICK, 8'($urandom), 1'($urandom), 7'($urandom)));
	endtask

	task automatic send_byte(logic [7:0] b, logic le);
		push_request(mk(OP_BYTE, b, le, 7'($urandom)));
	endtask

	// Trim the count so that no never-written store entry gets read.
	task automatic send_read(int cnt);
		int eff;
		eff = (cnt > READ_CAP) ? READ_CAP : cnt;
		if (eff > sb.written_hw)
			cnt = sb.written_hw;
		push_request(mk(OP_READ, 8'($urandom), 1'($urandom), cnt[6:0]));
	endtask

	// Build a whole frame with its CRC; optionally corrupt the CRC, and when noisy
	// sprinkle line-error bytes and ticks between the frame bytes.
	task automatic send_frame(logic [7:0] cmd, int len, bit bad, bit noisy);
		logic [7:0]  frame [$];
		logic [15:0] crc;
		frame.push_back(sb.start_cfg);
		frame.push_back(cmd);
		frame.push_back(8'(len));
		for (int i = 0; i < len; i++)
			frame.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (frame[i])
			crc = rx_frame_scoreboard::crc16_next(crc, frame[i]);
		if (bad)
			crc ^= 16'(1 << $urandom_range(0, 15));
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		foreach (frame[i]) begin
			if (noisy && $urandom_range(0, 11) == 0)
				send_byte(8'($urandom), 1'b1);
			if (noisy && $urandom_range(0, 19) == 0)
				send_tick();
			send_byte(frame[i], 1'b0);
		end
	endtask

	task automatic send_len_abort(logic [7:0] len);
		send_byte(sb.start_cfg, 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(len, 1'b0);
	endtask

	// Open a frame, leave it unfinished, then tick past the timeout when that is cheap.
	task automatic send_stalled_frame();
		int depth;
		int ticks;
		depth = $urandom_range(1, 4);
		send_byte(sb.start_cfg, 1'b0);
		if (depth > 1)
			send_byte(8'($urandom), 1'b0);
		if (depth > 2)
			send_byte(8'($urandom_range(2, 10)), 1'b0);
		if (depth > 3)
			send_byte(8'($urandom), 1'b0);
		if (sb.timeout_cfg <= 40)
			ticks = sb.timeout_cfg + 1 + $urandom_range(0, 1);
		else
			ticks = $urandom_range(1, 3);
		repeat (ticks) send_tick();
	endtask

	function automatic int pick_frame_len();
		int p;
		p = $urandom_range(0, 19);
		if (p < 14)
			return $urandom_range(0, 6);
		if (p < 19)
			return $urandom_range(7, 20);
		return $urandom_range(21, MAX_LEN);
	endfunction

	function automatic int pick_read_count();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5)
			return sb.wpos;
		if (p < 6)
			return 0;
		if (p < 8)
			return $urandom_range(1, BUFFER_DEPTH);
		return $urandom_range(0, 127);
	endfunction

	// One random scenario: well-formed frames most often, read out when a packet waits,
	// plus aborts, timeouts, noise, ticks and stray opcodes.
	task automatic random_episode();
		int         pick;
		logic [7:0] len;
		pick = $urandom_range(0, 99);
		if (sb.pkt_ready && pick < 85)
			send_read(pick_read_count());
		else if (pick < 45)
			send_frame(8'($urandom), pick_frame_len(), $urandom_range(0, 9) == 0, 1'b1);
		else if (pick < 55) begin
			case ($urandom_range(0, 2))
				0: len = 8'(MAX_LEN + 1);
				1: len = 8'hFF;
				default: len = 8'($urandom_range(MAX_LEN + 1, 255));
			endcase
			send_len_abort(len);
		end else if (pick < 65)
			send_stalled_frame();
		else if (pick < 77) begin
			repeat ($urandom_range(1, 4))
				send_byte(($urandom_range(0, 5) == 0) ? sb.start_cfg : 8'($urandom),
					$urandom_range(0, 2) == 0);
		end else if (pick < 82)
			push_request(mk(OP_NOP, 8'($urandom), 1'($urandom), 7'($urandom)));
		else if (pick < 90) begin
			repeat ($urandom_range(1, 3)) send_tick();
		end else
			send_read(pick_read_count());
	endtask

	// Bring the parser back to waiting for a start byte with no packet held.
	task automatic settle_parser();
		while (sb.pkt_ready || sb.phase != PH_WAIT) begin
			if (sb.pkt_ready)
				send_read(0);
			else
				send_byte(8'($urandom), 1'b0);
		end
	endtask

	// Drain, let the pipeline go quiet, then write both registers on back-to-back edges.
	task automatic apply_settings(logic [7:0] start_val, logic [15:0] timeout_val);
		req_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_START;
		cfg_data <= {8'h00, start_val};
		@(posedge clk);
		sb.configure(REG_START, {8'h00, start_val});
		cfg_index <= REG_TIMEOUT;
		cfg_data <= timeout_val;
		@(posedge clk);
		sb.configure(REG_TIMEOUT, timeout_val);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: check every accepted result, then decide next cycle's ready.
	// Short random stalls, plus one long hold-off on request from the stimulus.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (hold_off_cycles > 0) begin
				stall_left = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on reset settings (start byte 2, timeout 100).
		push_request(mk(OP_NOP, 8'hFF, 1'b1, 7'h7F));      // stray opcode: status only
		send_tick();                                        // tick while waiting: no event
		send_read(0);                                       // empty read: one status
		send_byte(START_RESET, 1'b1);                       // line error: drop the start byte
		send_byte(8'h00, 1'b0);                             // not a start byte
		send_frame(8'hFF, 0, 1'b0, 1'b0);                   // zero-length frame, good CRC
		send_byte(START_RESET, 1'b0);                       // ignored while packet waits
		send_read(5);                                       // drain the packet, clear ready
		send_frame(8'h00, 1, 1'b1, 1'b0);                   // CRC mismatch
		send_len_abort(8'(MAX_LEN + 1));                    // just over the length limit

		// Start 0xFF, timeout 0: the first tick inside a frame abandons it.
		apply_settings(8'hFF, 16'd0);
		send_byte(8'hFF, 1'b0);
		send_tick();
		// Fill the whole store once, then read past the cap.
		send_frame(8'($urandom), MAX_LEN, 1'b0, 1'b0);
		send_read(127);
		while (counted < 130) random_episode();

		// Start 0x00, timeout 65534: ticks inside a frame never trip it here.
		apply_settings(8'h00, 16'd65534);
		settle_parser();
		while (counted < 230) random_episode();

		// Random start byte, short timeout; hold off the result side midway so the
		// queue fills and requests back up.
		apply_settings(8'($urandom_range(1, 254)), 16'($urandom_range(3, 12)));
		while (counted < 285) random_episode();
		hold_off_cycles = LONG_HOLD;
		while (counted < 340) random_episode();

		// Random start byte and timeout; finish without any gaps or stalls.
		apply_settings(8'($urandom), 16'($urandom_range(0, 30)));
		while (counted < 390) random_episode();
		idle_on = 1'b0;
		while (counted < 450) random_episode();

		req_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
src/crcfr_pkg.sv
src/crcfr_front.sv
src/crcfr_queue.sv
src/crcfr_back.sv
src/crc_framed_packet_receiver_core.sv
verif/crc_framed_packet_receiver_core_tb.sv
